FILE: rtl/depth_pixel_backprojection_macros.svh
// Assertion macros shared by the depth pixel back-projection RTL.
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DPB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

FILE: rtl/dpb_pkg.sv
// Package with the widths, register indexes and shared types of the back-projection block.
`timescale 1ns / 1ps

package dpb_pkg;

  localparam int unsigned CoordInW  = 12;
  localparam int unsigned DepthInW  = 16;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned PackW     = 24;
  localparam int unsigned PrincW    = 16;
  localparam int unsigned InvW      = 32;
  localparam int unsigned OffMagW   = 16;
  localparam int unsigned MagDepW   = 32;
  localparam int unsigned FullProdW = 64;
  localparam int unsigned FracShift = 36;
  localparam int unsigned OutCoordW = 29;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIdxW-1:0] CfgPrincipalX = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgPrincipalY = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgInvFocalX  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgInvFocalY  = 8'd3;

  typedef struct packed {
    logic [PrincW-1:0] principal_x;
    logic [PrincW-1:0] principal_y;
    logic [InvW-1:0]   inv_focal_x;
    logic [InvW-1:0]   inv_focal_y;
  } dpb_cfg_t;

  // One classified pixel: offset magnitudes and signs, depth and packed colour.
  typedef struct packed {
    logic [OffMagW-1:0]  mag_x;
    logic                neg_x;
    logic [OffMagW-1:0]  mag_y;
    logic                neg_y;
    logic [DepthInW-1:0] depth;
    logic [PackW-1:0]    color;
  } dpb_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dpb_q_status_t;

endpackage

FILE: rtl/dpb_if.sv
// Channel interfaces of the back-projection block: pixels in, points out, register writes.
`timescale 1ns / 1ps

interface dpb_pixel_if import dpb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CoordInW-1:0] pixel_row;
  logic [CoordInW-1:0] pixel_col;
  logic [DepthInW-1:0] depth_mm;
  logic [ColorW-1:0]   color_first;
  logic [ColorW-1:0]   color_second;
  logic [ColorW-1:0]   color_third;

  modport source (output valid, pixel_row, pixel_col, depth_mm, color_first, color_second,
                  color_third, input ready);
  modport sink (input valid, pixel_row, pixel_col, depth_mm, color_first, color_second,
                color_third, output ready);
endinterface

interface dpb_point_if import dpb_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OutCoordW-1:0] point_x_mm;
  logic signed [OutCoordW-1:0] point_y_mm;
  logic [DepthInW-1:0]         point_z_mm;
  logic [PackW-1:0]            packed_color;

  modport source (output valid, point_x_mm, point_y_mm, point_z_mm, packed_color,
                  input ready);
  modport sink (input valid, point_x_mm, point_y_mm, point_z_mm, packed_color,
                output ready);
endinterface

interface dpb_cfg_if import dpb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block: registers, front end, queue, back end.
//
// Usage: pixels arrive on pixel_i, one transaction per pixel, carrying row, column, depth in
// millimetres and three colour bytes. A pixel whose depth is zero is accepted and dropped.
// Every other pixel yields one transaction on point_o with x, y and z in millimetres and the
// packed colour. Registers are written through cfg_i, which is always ready; indexes that
// name no register are ignored. Write them only while no pixel is in flight.
// Throughput is one pixel per cycle while point_o is not stalled, set by the pipelined back
// end (offset times depth, then times the reciprocal focal length, then flooring), which
// starts one item in every cycle while the receiver takes its output.
// The front register and back end are separated by a four-entry queue. When the receiver
// stalls, the back end holds its output and stops, the queue fills, and pixel_i.ready drops
// only once the queue and the front register are full; no transaction is lost.
// Reset clears all valid flags, the queue pointers and the registers (all to zero); there
// is no clearing pass and the block accepts pixels from the first cycle after reset.
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_macros.svh"

module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpb_pixel_if.sink   pixel_i,
  dpb_point_if.source point_o,
  dpb_cfg_if.sink     cfg_i
);

  dpb_cfg_t      cfg_q;
  logic          push, pop;
  dpb_item_t     front_item, queue_item;
  dpb_q_status_t q_status;

  // Register file: a transaction on cfg_i writes the addressed register at once.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgPrincipalX: cfg_q.principal_x <= cfg_i.data[PrincW-1:0];
        CfgPrincipalY: cfg_q.principal_y <= cfg_i.data[PrincW-1:0];
        CfgInvFocalX:  cfg_q.inv_focal_x <= cfg_i.data[InvW-1:0];
        CfgInvFocalY:  cfg_q.inv_focal_y <= cfg_i.data[InvW-1:0];
        default: ;
      endcase
    end
  end

  // The front end classifies pixels and forms the offsets from the principal point.
  dpb_front #(
    .COORD_BITS(COORD_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pixel_i),
    .cfg_i   (cfg_q),
    .q_full_i(q_status.full),
    .push_o  (push),
    .item_o  (front_item)
  );

  dpb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .status_o(q_status)
  );

  // The back end does the arithmetic and owns the output register.
  dpb_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .empty_i(q_status.empty),
    .item_i (queue_item),
    .pop_o  (pop),
    .point_o(point_o)
  );

  // The queue is never written while full nor read while empty.
  `DPB_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push, !q_status.full)
  `DPB_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop, !q_status.empty)
  // Zero depths are dropped, so every delivered point lies in front of the camera.
  `DPB_ASSERT_IMPL(a_depth_nonzero, clk_i, rst_ni, point_o.valid, point_o.point_z_mm != '0)
  // A push into an empty queue that is not read leaves it non-empty in the next cycle.
  `DPB_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, push && !pop, !q_status.empty)

endmodule

FILE: rtl/dpb_front.sv
// Front end: accepts pixels, drops zero depths and forms the signed principal-point offsets.
`timescale 1ns / 1ps

module dpb_front import dpb_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpb_pixel_if.sink pixel_i,
  input  dpb_cfg_t  cfg_i,
  input  logic      q_full_i,
  output logic      push_o,
  output dpb_item_t item_o
);

  localparam int unsigned CoordUse = (COORD_BITS < CoordInW) ? COORD_BITS : CoordInW;
  localparam logic [CoordInW-1:0] CoordMask = CoordInW'((1 << CoordUse) - 1);
  localparam logic [DepthInW-1:0] DepthMask = DepthInW'((1 << DEPTH_BITS) - 1);

  logic [CoordInW-1:0]   row_m, col_m;
  logic [DepthInW-1:0]   depth_m;
  logic signed [PrincW:0] off_x, off_y;
  logic [PrincW:0]       neg_off_x, neg_off_y;
  logic                  advance;
  logic                  f_vld_q;
  dpb_item_t             item_d, item_q;

  assign row_m   = pixel_i.pixel_row & CoordMask;
  assign col_m   = pixel_i.pixel_col & CoordMask;
  assign depth_m = pixel_i.depth_mm & DepthMask;

  // Pixel coordinate in Q.4 minus the Q12.4 principal point.
  assign off_x     = $signed({1'b0, col_m, 4'b0000}) - $signed({1'b0, cfg_i.principal_x});
  assign off_y     = $signed({1'b0, row_m, 4'b0000}) - $signed({1'b0, cfg_i.principal_y});
  assign neg_off_x = -off_x;
  assign neg_off_y = -off_y;

  always_comb begin
    item_d.neg_x = off_x[PrincW];
    item_d.neg_y = off_y[PrincW];
    item_d.mag_x = off_x[PrincW] ? neg_off_x[OffMagW-1:0] : off_x[OffMagW-1:0];
    item_d.mag_y = off_y[PrincW] ? neg_off_y[OffMagW-1:0] : off_y[OffMagW-1:0];
    item_d.depth = depth_m;
    item_d.color = {pixel_i.color_first, pixel_i.color_second, pixel_i.color_third};
  end

  assign push_o        = f_vld_q && !q_full_i;
  assign advance       = !f_vld_q || push_o;
  assign pixel_i.ready = advance;
  assign item_o        = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (advance) begin
      f_vld_q <= pixel_i.valid && (depth_m != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pixel_i.valid) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: rtl/dpb_queue.sv
// Short queue of classified pixels between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module dpb_queue import dpb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dpb_item_t     item_i,
  input  logic          pop_i,
  output dpb_item_t     item_o,
  output dpb_q_status_t status_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  dpb_item_t         slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;

  assign status_o.full  = (count_q == (PtrW+1)'(Depth));
  assign status_o.empty = (count_q == '0);
  assign item_o         = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/dpb_back.sv
// Back end: multiplies offsets by depth and reciprocal focal length, floors and holds the result.
`timescale 1ns / 1ps

module dpb_back import dpb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dpb_cfg_t    cfg_i,
  input  logic        empty_i,
  input  dpb_item_t   item_i,
  output logic        pop_o,
  dpb_point_if.source point_o
);

  logic                 en;
  logic                 s1_vld_q, s2_vld_q, out_vld_q;
  logic [MagDepW-1:0]   m_x_q, m_y_q;
  logic                 s1_neg_x_q, s1_neg_y_q, s2_neg_x_q, s2_neg_y_q;
  logic [DepthInW-1:0]  s1_depth_q, s2_depth_q, out_z_q;
  logic [PackW-1:0]     s1_color_q, s2_color_q, out_color_q;
  logic [FullProdW-1:0] p_x_q, p_y_q;
  logic [OutCoordW-1:0] out_x_q, out_y_q;

  // Floor of the signed Q.36 product, returned in two's complement.
  function automatic logic [OutCoordW-1:0] floor_coord(logic [FullProdW-1:0] p, logic neg);
    logic [OutCoordW-1:0] q;
    logic                 rem;
    q   = {1'b0, p[FullProdW-1:FracShift]};
    rem = |p[FracShift-1:0];
    if (neg) begin
      floor_coord = '0 - (q + {{(OutCoordW-1){1'b0}}, rem});
    end else begin
      floor_coord = q;
    end
  endfunction

  assign en    = !out_vld_q || point_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= pop_o;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_x_q       <= {{(MagDepW-OffMagW){1'b0}}, item_i.mag_x}
                     * {{(MagDepW-DepthInW){1'b0}}, item_i.depth};
      m_y_q       <= {{(MagDepW-OffMagW){1'b0}}, item_i.mag_y}
                     * {{(MagDepW-DepthInW){1'b0}}, item_i.depth};
      s1_neg_x_q  <= item_i.neg_x;
      s1_neg_y_q  <= item_i.neg_y;
      s1_depth_q  <= item_i.depth;
      s1_color_q  <= item_i.color;

      p_x_q       <= {{(FullProdW-MagDepW){1'b0}}, m_x_q}
                     * {{(FullProdW-InvW){1'b0}}, cfg_i.inv_focal_x};
      p_y_q       <= {{(FullProdW-MagDepW){1'b0}}, m_y_q}
                     * {{(FullProdW-InvW){1'b0}}, cfg_i.inv_focal_y};
      s2_neg_x_q  <= s1_neg_x_q;
      s2_neg_y_q  <= s1_neg_y_q;
      s2_depth_q  <= s1_depth_q;
      s2_color_q  <= s1_color_q;

      out_x_q     <= floor_coord(p_x_q, s2_neg_x_q);
      out_y_q     <= floor_coord(p_y_q, s2_neg_y_q);
      out_z_q     <= s2_depth_q;
      out_color_q <= s2_color_q;
    end
  end

  assign point_o.valid        = out_vld_q;
  assign point_o.point_x_mm   = $signed(out_x_q);
  assign point_o.point_y_mm   = $signed(out_y_q);
  assign point_o.point_z_mm   = out_z_q;
  assign point_o.packed_color = out_color_q;

endmodule
